/* sv/two_axis_stepper_burst_planner_top_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the two-axis stepper burst planner
// Each macro expects i_clk and i_rst_n in the scope of its use.
// ----------------------------------------------------------------------------
`ifndef TWO_AXIS_STEPPER_BURST_PLANNER_TOP_MACROS_SVH
`define TWO_AXIS_STEPPER_BURST_PLANNER_TOP_MACROS_SVH

// same-cycle implication
`define TSBP_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tsbp assertion failed");

// next-cycle implication
`define TSBP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tsbp assertion failed");

`endif

/* sv/tsbp_pkg.sv */
// ----------------------------------------------------------------------------
// tsbp_pkg
// Types and constants shared by the stepper burst planner modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tsbp_pkg;

    localparam int unsigned START_RELOAD = 1199;
    localparam int unsigned START_MAX    = 30;
    localparam int unsigned RUN_MAX      = 256;
    localparam int unsigned MICROSTEP    = 8;
    localparam int unsigned MICRO_SHIFT  = $clog2(MICROSTEP);
    localparam int unsigned SCALE_DIV    = 4;
    localparam int unsigned DIV_SHIFT    = $clog2(SCALE_DIV);
    localparam logic [15:0] SAT16        = 16'hFFFF;
    localparam int unsigned ADDR_W       = 5;

    typedef enum logic [1:0] {
        ACT_MOVE   = 2'd0,
        ACT_X_DONE = 2'd1,
        ACT_Y_DONE = 2'd2,
        ACT_TOUCH  = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        REG_X_SCALE      = 3'd0,
        REG_Y_SCALE      = 3'd1,
        REG_X_BACKLASH   = 3'd2,
        REG_Y_BACKLASH   = 3'd3,
        REG_X_HOME_EXTRA = 3'd4,
        REG_Y_HOME_EXTRA = 3'd5,
        REG_X_RUN_RELOAD = 3'd6,
        REG_Y_RUN_RELOAD = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [9:0]  x_scale;
        logic [9:0]  y_scale;
        logic [7:0]  x_backlash;
        logic [7:0]  y_backlash;
        logic [11:0] x_home_extra;
        logic [11:0] y_home_extra;
        logic [15:0] x_run_reload;
        logic [15:0] y_run_reload;
    } t_cfg;

    typedef struct packed {
        logic        axis;
        logic        reverse_dir;
        logic [8:0]  burst_pulses;
        logic [15:0] burst_reload;
        logic        x_done_flag;
        logic        y_done_flag;
        logic        press_tap;
        logic        send_report;
        logic        last;
    } t_result;

    typedef struct packed {
        t_result res0;
        t_result res1;
        logic    two;
    } t_plan;

endpackage

`default_nettype wire

/* sv/tsbp_in_if.sv */
// ----------------------------------------------------------------------------
// tsbp_in_if
// Command channel: action code and target position.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface tsbp_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] x_target;
    logic [7:0] y_target;

    modport source (output valid, output action, output x_target, output y_target,
                    input ready);
    modport sink   (input valid, input action, input x_target, input y_target,
                    output ready);
endinterface

`default_nettype wire

/* sv/tsbp_out_if.sv */
// ----------------------------------------------------------------------------
// tsbp_out_if
// Result channel: one burst or touch result per item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface tsbp_out_if;
    logic        valid;
    logic        ready;
    logic        axis;
    logic        reverse_dir;
    logic [8:0]  burst_pulses;
    logic [15:0] burst_reload;
    logic        x_done_flag;
    logic        y_done_flag;
    logic        press_tap;
    logic        send_report;
    logic        last;

    modport source (output valid, output axis, output reverse_dir, output burst_pulses,
                    output burst_reload, output x_done_flag, output y_done_flag,
                    output press_tap, output send_report, output last, input ready);
    modport sink   (input valid, input axis, input reverse_dir, input burst_pulses,
                    input burst_reload, input x_done_flag, input y_done_flag,
                    input press_tap, input send_report, input last, output ready);
endinterface

`default_nettype wire

/* sv/tsbp_cfg_regs.sv */
// ----------------------------------------------------------------------------
// tsbp_cfg_regs
// APB-style register file for scale, backlash, homing and reload settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tsbp_cfg_regs (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [tsbp_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready,
    output tsbp_pkg::t_cfg                   o_cfg
);
    import tsbp_pkg::*;

    t_cfg     r_cfg;
    logic     wr_en;
    t_reg_idx idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.x_scale      <= 10'd244;
            r_cfg.y_scale      <= 10'd136;
            r_cfg.x_backlash   <= 8'd50;
            r_cfg.y_backlash   <= 8'd40;
            r_cfg.x_home_extra <= 12'd850;
            r_cfg.y_home_extra <= 12'd800;
            r_cfg.x_run_reload <= 16'd449;
            r_cfg.y_run_reload <= 16'd499;
        end else if (wr_en) begin
            case (idx)
                REG_X_SCALE:      r_cfg.x_scale      <= pwdata[9:0];
                REG_Y_SCALE:      r_cfg.y_scale      <= pwdata[9:0];
                REG_X_BACKLASH:   r_cfg.x_backlash   <= pwdata[7:0];
                REG_Y_BACKLASH:   r_cfg.y_backlash   <= pwdata[7:0];
                REG_X_HOME_EXTRA: r_cfg.x_home_extra <= pwdata[11:0];
                REG_Y_HOME_EXTRA: r_cfg.y_home_extra <= pwdata[11:0];
                REG_X_RUN_RELOAD: r_cfg.x_run_reload <= pwdata[15:0];
                REG_Y_RUN_RELOAD: r_cfg.y_run_reload <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_X_SCALE:      prdata = 32'(r_cfg.x_scale);
            REG_Y_SCALE:      prdata = 32'(r_cfg.y_scale);
            REG_X_BACKLASH:   prdata = 32'(r_cfg.x_backlash);
            REG_Y_BACKLASH:   prdata = 32'(r_cfg.y_backlash);
            REG_X_HOME_EXTRA: prdata = 32'(r_cfg.x_home_extra);
            REG_Y_HOME_EXTRA: prdata = 32'(r_cfg.y_home_extra);
            REG_X_RUN_RELOAD: prdata = 32'(r_cfg.x_run_reload);
            REG_Y_RUN_RELOAD: prdata = 32'(r_cfg.y_run_reload);
            default:          prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

/* sv/tsbp_planner.sv */
// ----------------------------------------------------------------------------
// tsbp_planner
// Axis state and the single-pass plan of one registered command.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tsbp_planner (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_fire,
    input  wire logic [1:0]     i_action,
    input  wire logic [7:0]     i_x_target,
    input  wire logic [7:0]     i_y_target,
    input  tsbp_pkg::t_cfg      i_cfg,
    output tsbp_pkg::t_plan     o_plan
);
    import tsbp_pkg::*;

    typedef struct packed {
        logic [15:0] rem;
        logic        rev;
        logic [8:0]  burst;
    } t_axis_plan;

    typedef struct packed {
        logic [15:0] rem;
        logic [8:0]  burst;
    } t_run_plan;

    logic [7:0]  r_x_pos, r_y_pos, n_x_pos, n_y_pos;
    logic [15:0] r_x_rem, r_y_rem, n_x_rem, n_y_rem;
    logic        r_x_rev, r_y_rev, n_x_rev, n_y_rev;
    logic        r_x_fin, r_y_fin, n_x_fin, n_y_fin;

    t_action     act;
    logic        home;
    t_axis_plan  xm, ym;
    t_run_plan   xr, yr;
    t_result     res0, res1;
    logic        two;
    logic        tap, rep;

    function automatic t_axis_plan plan_move(input logic [7:0] pos, input logic [7:0] tgt,
                                             input logic [9:0] scale,
                                             input logic [7:0] backlash,
                                             input logic is_home,
                                             input logic [11:0] home_extra);
        logic [7:0]  delta;
        logic [17:0] prod;
        logic [19:0] raw;
        logic [16:0] hsum;
        t_axis_plan  p;
        p.rev = (tgt < pos);
        delta = p.rev ? (pos - tgt) : (tgt - pos);
        prod  = 18'(scale) * 18'(delta);
        raw   = 20'(prod >> DIV_SHIFT) << MICRO_SHIFT;
        if (p.rev) begin
            raw = raw + 20'(backlash);
        end
        p.rem = (raw > 20'(SAT16)) ? SAT16 : raw[15:0];
        if (is_home) begin
            hsum  = 17'(p.rem) + 17'(home_extra);
            p.rem = hsum[16] ? SAT16 : hsum[15:0];
            p.rev = 1'b1;
        end
        // start burst comes off the fresh count
        p.burst = (p.rem < 16'(START_MAX)) ? p.rem[8:0] : 9'(START_MAX);
        p.rem   = p.rem - 16'(p.burst);
        return p;
    endfunction

    function automatic t_run_plan plan_run(input logic [15:0] rem);
        t_run_plan p;
        p.burst = (rem < 16'(RUN_MAX)) ? rem[8:0] : 9'(RUN_MAX);
        p.rem   = rem - 16'(p.burst);
        return p;
    endfunction

    assign act  = t_action'(i_action);
    assign home = (i_x_target == 8'd0) && (i_y_target == 8'd0);

    always_comb begin
        xm = plan_move(r_x_pos, i_x_target, i_cfg.x_scale, i_cfg.x_backlash, home,
                       i_cfg.x_home_extra);
        ym = plan_move(r_y_pos, i_y_target, i_cfg.y_scale, i_cfg.y_backlash, home,
                       i_cfg.y_home_extra);
        xr = plan_run(r_x_rem);
        yr = plan_run(r_y_rem);
    end

    // next state
    always_comb begin
        n_x_pos = r_x_pos;
        n_y_pos = r_y_pos;
        n_x_rem = r_x_rem;
        n_y_rem = r_y_rem;
        n_x_rev = r_x_rev;
        n_y_rev = r_y_rev;
        n_x_fin = r_x_fin;
        n_y_fin = r_y_fin;
        tap     = 1'b0;
        rep     = 1'b0;
        case (act)
            ACT_MOVE: begin
                n_x_pos = i_x_target;
                n_y_pos = i_y_target;
                n_x_rem = xm.rem;
                n_y_rem = ym.rem;
                n_x_rev = xm.rev;
                n_y_rev = ym.rev;
                n_x_fin = (xm.rem == 16'd0);
                n_y_fin = (ym.rem == 16'd0);
            end
            ACT_X_DONE: begin
                n_x_rem = xr.rem;
                if (xr.rem == 16'd0) begin
                    n_x_fin = 1'b1;
                end
            end
            ACT_Y_DONE: begin
                n_y_rem = yr.rem;
                if (yr.rem == 16'd0) begin
                    n_y_fin = 1'b1;
                end
            end
            ACT_TOUCH: begin
                if (r_x_fin && r_y_fin) begin
                    n_x_fin = 1'b0;
                    n_y_fin = 1'b0;
                    rep     = 1'b1;
                    tap     = (r_x_pos != 8'd0) || (r_y_pos != 8'd0);
                end
            end
            default: begin
            end
        endcase
    end

    // results
    always_comb begin
        res0              = '0;
        res1              = '0;
        two               = 1'b0;
        res0.x_done_flag  = n_x_fin;
        res0.y_done_flag  = n_y_fin;
        res1.x_done_flag  = n_x_fin;
        res1.y_done_flag  = n_y_fin;
        res1.axis         = 1'b1;
        res1.last         = 1'b1;
        case (act)
            ACT_MOVE: begin
                two               = 1'b1;
                res0.reverse_dir  = xm.rev;
                res0.burst_pulses = xm.burst;
                res0.burst_reload = (xm.burst != 9'd0) ? 16'(START_RELOAD) : 16'd0;
                res1.reverse_dir  = ym.rev;
                res1.burst_pulses = ym.burst;
                res1.burst_reload = (ym.burst != 9'd0) ? 16'(START_RELOAD) : 16'd0;
            end
            ACT_X_DONE: begin
                res0.last         = 1'b1;
                res0.reverse_dir  = r_x_rev;
                res0.burst_pulses = xr.burst;
                res0.burst_reload = (xr.burst != 9'd0) ? i_cfg.x_run_reload : 16'd0;
            end
            ACT_Y_DONE: begin
                res0.last         = 1'b1;
                res0.axis         = 1'b1;
                res0.reverse_dir  = r_y_rev;
                res0.burst_pulses = yr.burst;
                res0.burst_reload = (yr.burst != 9'd0) ? i_cfg.y_run_reload : 16'd0;
            end
            ACT_TOUCH: begin
                res0.last        = 1'b1;
                res0.press_tap   = tap;
                res0.send_report = rep;
            end
            default: begin
            end
        endcase
        o_plan.res0 = res0;
        o_plan.res1 = res1;
        o_plan.two  = two;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_pos <= 8'd0;
            r_y_pos <= 8'd0;
            r_x_rem <= 16'd0;
            r_y_rem <= 16'd0;
            r_x_rev <= 1'b0;
            r_y_rev <= 1'b0;
            r_x_fin <= 1'b0;
            r_y_fin <= 1'b0;
        end else if (i_fire) begin
            r_x_pos <= n_x_pos;
            r_y_pos <= n_y_pos;
            r_x_rem <= n_x_rem;
            r_y_rem <= n_y_rem;
            r_x_rev <= n_x_rev;
            r_y_rev <= n_y_rev;
            r_x_fin <= n_x_fin;
            r_y_fin <= n_y_fin;
        end
    end

endmodule

`default_nettype wire

/* sv/tsbp_result_buf.sv */
// ----------------------------------------------------------------------------
// tsbp_result_buf
// Two-slot result register that drains a plan one item per cycle while o_res.ready is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "two_axis_stepper_burst_planner_top_macros.svh"

module tsbp_result_buf (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_load,
    input  tsbp_pkg::t_plan i_plan,
    output logic            o_room,
    tsbp_out_if.source      o_res
);
    import tsbp_pkg::*;

    logic [1:0] r_cnt, n_cnt;
    t_result    r_slot0, r_slot1;
    logic       take;

    assign take   = o_res.valid && o_res.ready;
    // accept a new plan when empty or when the final slot leaves now
    assign o_room = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && take);

    always_comb begin
        n_cnt = r_cnt;
        if (i_load) begin
            n_cnt = i_plan.two ? 2'd2 : 2'd1;
        end else if (take) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_slot0 <= i_plan.res0;
            r_slot1 <= i_plan.res1;
        end else if (take) begin
            r_slot0 <= r_slot1;
        end
    end

    assign o_res.valid        = (r_cnt != 2'd0);
    assign o_res.axis         = r_slot0.axis;
    assign o_res.reverse_dir  = r_slot0.reverse_dir;
    assign o_res.burst_pulses = r_slot0.burst_pulses;
    assign o_res.burst_reload = r_slot0.burst_reload;
    assign o_res.x_done_flag  = r_slot0.x_done_flag;
    assign o_res.y_done_flag  = r_slot0.y_done_flag;
    assign o_res.press_tap    = r_slot0.press_tap;
    assign o_res.send_report  = r_slot0.send_report;
    assign o_res.last         = r_slot0.last;

    `TSBP_ASSERT_IMPL(a_single_is_last, r_cnt == 2'd1, r_slot0.last)
    `TSBP_ASSERT_IMPL(a_pair_order, r_cnt == 2'd2, !r_slot0.last && r_slot1.last)
    `TSBP_ASSERT_NEXT(a_pair_drains, (r_cnt == 2'd2) && take, r_cnt == 2'd1)

endmodule

`default_nettype wire

/* sv/two_axis_stepper_burst_planner_top.sv */
// ----------------------------------------------------------------------------
// two_axis_stepper_burst_planner_top
// Plans start and follow-on step bursts for two stepper axes.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake         | payload
//  i_cmd    | in  | valid / ready     | action, x_target, y_target
//  o_res    | out | valid / ready     | axis .. last, one result per item
//  apb      | in  | psel/penable/pwrite, pready tied high | 8 registers at 4*i
//
//  An accepted command is held in the input register; its plan is computed
//  combinationally from it and loaded into the two-slot result register.
//  Burst-finished and touch commands sustain one item per cycle while o_res
//  is ready; a move yields two results, which leave one at a time by the single result port.
//  Synchronous active-low reset clears the axis state and restores defaults.
//  A stalled result port holds the input register once the result slots fill.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module two_axis_stepper_burst_planner_top (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    tsbp_in_if.sink                          i_cmd,
    tsbp_out_if.source                       o_res,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [tsbp_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready
);
    import tsbp_pkg::*;

    logic       r_in_valid;
    logic [1:0] r_action;
    logic [7:0] r_x_target, r_y_target;
    logic       room, fire, in_take;
    t_cfg       cfg;
    t_plan      plan;

    assign fire        = r_in_valid && room;
    assign i_cmd.ready = !r_in_valid || fire;
    assign in_take     = i_cmd.valid && i_cmd.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_action   <= i_cmd.action;
            r_x_target <= i_cmd.x_target;
            r_y_target <= i_cmd.y_target;
        end
    end

    tsbp_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    tsbp_planner u_plan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (fire),
        .i_action   (r_action),
        .i_x_target (r_x_target),
        .i_y_target (r_y_target),
        .i_cfg      (cfg),
        .o_plan     (plan)
    );

    tsbp_result_buf u_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (fire),
        .i_plan  (plan),
        .o_room  (room),
        .o_res   (o_res)
    );

endmodule

`default_nettype wire
